>>> design/rm2q_pkg.sv
// Shared constants for the rotation matrix to quaternion pipeline.
package rm2q_pkg;
  localparam int FRAC_BITS_DEF = 14;
  localparam int ELEM_W = 16;
  localparam int NUM_ELEM = 9;
  localparam int NUM_PART = 4;
  localparam int KEY_W = 16;
  localparam logic [KEY_W-1:0] LIM_POS = 16'h7fff;
  localparam logic [KEY_W-1:0] LIM_NEG = 16'h8000;
endpackage

>>> design/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion: fully pipelined, one matrix per cycle while m_tready is high.
//
// Input beat on s_*: nine signed entries of a 3x3 rotation matrix, stored by
// columns, each FRAC_BITS fractional bits. Output beat on m_*: quaternion
// x, y, z, w rounded to nearest and saturated, plus an invalid flag in
// m_tuser that is set, with all parts zero, when the trace term is not
// positive.
// The pipeline holds one stage for branch choice and trace term, one for
// magnitudes and the squaring multiplier, sixteen stages that each settle one
// bit of the scaled result by an add and compare, and the output register.
// Throughput is one beat per cycle while m_tready is high. Every stage holds its own valid bit and
// advances whenever the stage after it is empty or advancing, so a stalled
// receiver fills the bubbles first and only then lowers s_tready.
// Reset clears all valid bits; no beat is in flight after reset.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // m_c1x, m_c1y, m_c1z, m_c2x, m_c2y, m_c2z, m_c3x, m_c3y, m_c3z
  input  logic [rm2q_pkg::NUM_ELEM*rm2q_pkg::ELEM_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // quat_x, quat_y, quat_z, quat_w
  output logic [rm2q_pkg::NUM_PART*rm2q_pkg::ELEM_W-1:0] m_tdata,
  // invalid
  output logic m_tuser
);
  import rm2q_pkg::*;

  localparam int TW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int CW = 2 * TW + 2 * FRAC_BITS + 4;
  localparam int NSTG = KEY_W;
  localparam logic signed [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [CW-1:0]    r;
    logic [KEY_W-1:0] k;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_PART-1:0] ln;
    logic [CW-1:0]        s;
    logic                 inv;
  } srch_t;

  // ---------------- stage 1: branch, trace term, raw parts
  logic signed [TW-1:0] a [NUM_ELEM];
  logic signed [TW-1:0] t_c;
  logic signed [TW-1:0] q_c [NUM_PART];
  logic signed [TW-1:0] t1;
  logic signed [TW-1:0] q1 [NUM_PART];
  logic v1, en1;

  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      a[i] = TW'($signed(s_tdata[ELEM_W*i +: ELEM_W]));
    end
    if (a[8] < 0) begin
      if (a[0] > a[4]) begin
        t_c = ONE + a[0] - a[4] - a[8];
        q_c[0] = t_c;         q_c[1] = a[1] + a[3];
        q_c[2] = a[6] + a[2]; q_c[3] = a[5] - a[7];
      end else begin
        t_c = ONE - a[0] + a[4] - a[8];
        q_c[0] = a[1] + a[3]; q_c[1] = t_c;
        q_c[2] = a[5] + a[7]; q_c[3] = a[6] - a[2];
      end
    end else begin
      if (a[0] + a[4] < 0) begin
        t_c = ONE - a[0] - a[4] + a[8];
        q_c[0] = a[6] + a[2]; q_c[1] = a[5] + a[7];
        q_c[2] = t_c;         q_c[3] = a[1] - a[3];
      end else begin
        t_c = ONE + a[0] + a[4] + a[8];
        q_c[0] = a[5] - a[7]; q_c[1] = a[6] - a[2];
        q_c[2] = a[1] - a[3]; q_c[3] = t_c;
      end
    end
  end

  // ---------------- stage 2: validity, magnitudes, squares
  srch_t srch [NSTG+1];
  logic  vs   [NSTG+1];
  logic  ens  [NSTG+1];
  srch_t s2_c;
  logic [TW-1:0]   mag [NUM_PART];
  logic [2*TW-1:0] sq  [NUM_PART];

  always_comb begin
    s2_c = '0;
    s2_c.inv = t1[TW-1] || (t1 == '0);
    s2_c.s = CW'(unsigned'(t1)) << FRAC_BITS;
    for (int i = 0; i < NUM_PART; i++) begin
      s2_c.ln[i].neg = q1[i][TW-1];
      mag[i] = q1[i][TW-1] ? TW'(-q1[i]) : TW'(q1[i]);
      sq[i] = mag[i] * mag[i];
      s2_c.ln[i].r = CW'(sq[i]) << (2 * FRAC_BITS);
    end
  end

  // ---------------- output register, handshake enables, stage 1 and 2 registers
  logic vo, eno;
  logic [NUM_PART*ELEM_W-1:0] qo;
  logic [NUM_PART*ELEM_W-1:0] qo_next;
  logic invo;

  assign eno = !vo || m_tready;
  assign ens[NSTG] = !vs[NSTG] || eno;
  assign en1 = !v1 || ens[0];
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
    if (en1) begin
      t1 <= t_c;
      for (int i = 0; i < NUM_PART; i++) q1[i] <= q_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (ens[0]) begin
      vs[0] <= v1;
    end
    if (ens[0]) srch[0] <= s2_c;
  end

  // ---------------- search stages, one result bit each, MSB first
  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_srch
      localparam int J = NSTG - 1 - g;
      srch_t nxt;
      logic [CW-1:0]    sum;
      logic [KEY_W-1:0] cand;
      logic [KEY_W-1:0] lim;

      assign ens[g] = !vs[g] || ens[g+1];

      always_comb begin
        nxt = srch[g];
        for (int i = 0; i < NUM_PART; i++) begin
          sum = srch[g].ln[i].x + (srch[g].ln[i].y << (J + 2)) - (srch[g].ln[i].y << 1)
              + (srch[g].s << (2 * J + 2)) - (srch[g].s << (J + 2)) + srch[g].s;
          cand = srch[g].ln[i].k | (KEY_W'(1) << J);
          lim = srch[g].ln[i].neg ? LIM_NEG : LIM_POS;
          if (sum <= srch[g].ln[i].r && cand <= lim) begin
            nxt.ln[i].k = cand;
            nxt.ln[i].x = srch[g].ln[i].x + (srch[g].ln[i].y << (J + 2))
                        + (srch[g].s << (2 * J + 2));
            nxt.ln[i].y = srch[g].ln[i].y + (srch[g].s << (J + 1));
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vs[g+1] <= 1'b0;
        end else if (ens[g+1]) begin
          vs[g+1] <= vs[g];
        end
        if (ens[g+1]) srch[g+1] <= nxt;
      end
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < NUM_PART; i++) begin
      if (srch[NSTG].inv) begin
        qo_next[ELEM_W*i +: ELEM_W] = '0;
      end else if (srch[NSTG].ln[i].neg) begin
        qo_next[ELEM_W*i +: ELEM_W] = ELEM_W'(-srch[NSTG].ln[i].k);
      end else begin
        qo_next[ELEM_W*i +: ELEM_W] = srch[NSTG].ln[i].k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (eno) begin
      vo <= vs[NSTG];
    end
    if (eno) begin
      qo <= qo_next;
      invo <= srch[NSTG].inv;
    end
  end

  assign m_tvalid = vo;
  assign m_tdata = qo;
  assign m_tuser = invo;

`ifndef SYNTH
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("invalid beat carries nonzero parts");
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");
`endif
endmodule
